// File: hdl/mbm_pkg.sv
// Shared types, codes and constants of the Modbus RTU meter reader.
// Holds the transaction structs, the register map and the CRC-16 byte update.
// Depends on nothing; every other file of the block but mbm_ram imports it.
package mbm_pkg;

  localparam int NumQuantities = 5;

  localparam logic [1:0] ActRequest = 2'd0;
  localparam logic [1:0] ActRxByte  = 2'd1;
  localparam logic [1:0] ActTimeout = 2'd2;

  localparam logic KindTx      = 1'b0;
  localparam logic KindOutcome = 1'b1;

  localparam logic [2:0] StsAccepted  = 3'd0;
  localparam logic [2:0] StsZero      = 3'd1;
  localparam logic [2:0] StsOverLimit = 3'd2;
  localparam logic [2:0] StsShort     = 3'd3;
  localparam logic [2:0] StsHeader    = 3'd4;
  localparam logic [2:0] StsCrc       = 3'd5;

  localparam logic [2:0] RegSlaveAddr  = 3'd0;
  localparam logic [2:0] RegEnable     = 3'd1;
  localparam logic [2:0] RegVoltLimit  = 3'd2;
  localparam logic [2:0] RegCurrLimit  = 3'd3;
  localparam logic [2:0] RegPowerLimit = 3'd4;

  localparam int AddrWidth = 5;

  localparam logic [7:0]  SlaveAddrReset  = 8'h01;
  localparam logic [30:0] VoltLimitReset  = 31'h43C8_0000;
  localparam logic [30:0] CurrLimitReset  = 31'h42C8_0000;
  localparam logic [30:0] PowerLimitReset = 31'h46C3_5000;

  localparam logic [7:0]  FuncReadInput = 8'h04;
  localparam logic [7:0]  RespByteCount = 8'h04;
  localparam logic [15:0] RegCount      = 16'h0002;
  localparam logic [15:0] CrcPoly       = 16'hA001;
  localparam logic [15:0] CrcInit       = 16'hFFFF;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] quantity;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last_of_run;
    logic [2:0]  which_quantity;
    logic [31:0] reading;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic        enable;
    logic [30:0] voltage_limit;
    logic [30:0] current_limit;
    logic [30:0] power_limit;
  } cfg_t;

  typedef struct packed {
    logic        is_outcome;
    logic [2:0]  quantity;
    logic [2:0]  status;
    logic [31:0] data;
    logic [7:0]  addr;
  } job_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] reg_of_quantity(input logic [2:0] q);
    logic [15:0] r;
    unique case (q)
      3'd0:    r = 16'h0000;
      3'd1:    r = 16'h0006;
      3'd2:    r = 16'h000C;
      3'd3:    r = 16'h0156;
      3'd4:    r = 16'h0180;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/modbus_rtu_meter_reader.sv
// Top level of the Modbus RTU meter reader: registers, receive front end, emitter.
// Depends on mbm_pkg, mbm_regs, mbm_rx, mbm_emit and mbm_ram.
//
// A request transaction produces the eight bytes of a read-input-registers frame, one
// output transaction per cycle while the output is not stalled, with the CRC built a
// byte a cycle in the emitter. The front end takes received bytes and timeouts at one
// per cycle while the job register has room; the ninth byte or a timeout yields one
// outcome via the job register, a RAM read unless accepted, and the result register.
// A one-entry job register sits between the front end and the emitter and a result
// register drives the output, so new input is taken while a result waits. Held readings
// live in a RAM of NUM_QUANTITIES words, and per-entry valid flags make them read as
// zero after reset, with no clearing pass.
module modbus_rtu_meter_reader import mbm_pkg::*; #(
  parameter int NUM_QUANTITIES = NumQuantities
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  cfg_t cfg;
  logic job_valid, job_take;
  job_t job;

  mbm_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  mbm_rx #(
    .NumQ(NUM_QUANTITIES)
  ) u_rx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .job_valid_o(job_valid),
    .job_o      (job),
    .job_take_i (job_take)
  );

  mbm_emit #(
    .NumQ(NUM_QUANTITIES)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (job),
    .job_take_o (job_take),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

// File: hdl/mbm_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module mbm_ram #(
  parameter int Width = 32,
  parameter int Depth = 8
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/mbm_regs.sv
// APB-style configuration registers of the meter reader.
// Depends on mbm_pkg for the register map, reset values and cfg_t.
module mbm_regs import mbm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;

  assign idx    = paddr[AddrWidth-1:2];
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      unique case (idx)
        RegSlaveAddr:  cfg_d.slave_address = pwdata[7:0];
        RegEnable:     cfg_d.enable        = pwdata[0];
        RegVoltLimit:  cfg_d.voltage_limit = pwdata[30:0];
        RegCurrLimit:  cfg_d.current_limit = pwdata[30:0];
        RegPowerLimit: cfg_d.power_limit   = pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegSlaveAddr:  prdata = {24'd0, cfg_q.slave_address};
      RegEnable:     prdata = {31'd0, cfg_q.enable};
      RegVoltLimit:  prdata = {1'b0, cfg_q.voltage_limit};
      RegCurrLimit:  prdata = {1'b0, cfg_q.current_limit};
      RegPowerLimit: prdata = {1'b0, cfg_q.power_limit};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave_address <= SlaveAddrReset;
      cfg_q.enable        <= 1'b0;
      cfg_q.voltage_limit <= VoltLimitReset;
      cfg_q.current_limit <= CurrLimitReset;
      cfg_q.power_limit   <= PowerLimitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/mbm_rx.sv
// Front end: takes input transactions, tracks the response frame and queues jobs.
// Depends on mbm_pkg for item types, codes, the job struct and the CRC update.
module mbm_rx import mbm_pkg::*; #(
  parameter int NumQ = NumQuantities
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     job_valid_o,
  output job_t     job_o,
  input  logic     job_take_i
);

  logic        awaiting_q, awaiting_d;
  logic [2:0]  pend_q, pend_d;
  logic [3:0]  rx_cnt_q, rx_cnt_d;
  logic [15:0] crc_acc_q, crc_acc_d;
  logic        hdr_good_q, hdr_good_d;
  logic [31:0] data_q, data_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic        job_valid_q, job_valid_d;
  job_t        job_q, job_d;

  logic        accept, push, q_ok, limited;
  logic [30:0] limit;
  logic [2:0]  judge, final_sts;
  job_t        new_job;
  logic [7:0]  b;

  assign b          = in_item_i.rx_byte;
  assign in_ready_o = !job_valid_q || job_take_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_ok       = 32'(in_item_i.quantity) < NumQ;

  always_comb begin
    limited = 1'b1;
    limit   = '0;
    unique case (pend_q)
      3'd0:    limit = cfg_i.voltage_limit;
      3'd1:    limit = cfg_i.current_limit;
      3'd2:    limit = cfg_i.power_limit;
      default: limited = 1'b0;
    endcase
    if (data_q[30:0] == 31'd0) begin
      judge = StsZero;
    end else if (limited && (data_q[30:23] == 8'hFF) && (data_q[22:0] != 23'd0)) begin
      judge = StsOverLimit;
    end else if (limited && !data_q[31] && (data_q[30:0] > limit)) begin
      judge = StsOverLimit;
    end else begin
      judge = StsAccepted;
    end
  end

  always_comb begin
    priority if (!hdr_good_q) begin
      final_sts = StsHeader;
    end else if ({b, crc_lo_q} != crc_acc_q) begin
      final_sts = StsCrc;
    end else begin
      final_sts = judge;
    end
  end

  always_comb begin
    awaiting_d  = awaiting_q;
    pend_d      = pend_q;
    rx_cnt_d    = rx_cnt_q;
    crc_acc_d   = crc_acc_q;
    hdr_good_d  = hdr_good_q;
    data_d      = data_q;
    crc_lo_d    = crc_lo_q;
    job_d       = job_q;
    job_valid_d = job_valid_q && !job_take_i;
    push        = 1'b0;
    new_job     = '0;
    new_job.quantity = pend_q;
    new_job.data     = data_q;
    if (accept) begin
      unique case (in_item_i.action)
        ActRequest: begin
          if (cfg_i.enable && q_ok) begin
            push               = 1'b1;
            new_job.is_outcome = 1'b0;
            new_job.quantity   = in_item_i.quantity;
            new_job.addr       = cfg_i.slave_address;
            awaiting_d         = 1'b1;
            pend_d             = in_item_i.quantity;
            rx_cnt_d           = 4'd0;
            crc_acc_d          = CrcInit;
            hdr_good_d         = 1'b1;
            data_d             = '0;
            crc_lo_d           = '0;
          end
        end
        ActRxByte: begin
          if (awaiting_q) begin
            if (rx_cnt_q < 4'd7) begin
              crc_acc_d = crc16_byte(crc_acc_q, b);
              if (rx_cnt_q == 4'd0 && b != cfg_i.slave_address) hdr_good_d = 1'b0;
              if (rx_cnt_q == 4'd1 && b != FuncReadInput) hdr_good_d = 1'b0;
              if (rx_cnt_q == 4'd2 && b != RespByteCount) hdr_good_d = 1'b0;
              if (rx_cnt_q >= 4'd3) data_d = {data_q[23:0], b};
              rx_cnt_d = rx_cnt_q + 4'd1;
            end else if (rx_cnt_q == 4'd7) begin
              crc_lo_d = b;
              rx_cnt_d = 4'd8;
            end else begin
              rx_cnt_d           = 4'd0;
              awaiting_d         = 1'b0;
              push               = 1'b1;
              new_job.is_outcome = 1'b1;
              new_job.status     = final_sts;
            end
          end
        end
        ActTimeout: begin
          if (awaiting_q) begin
            rx_cnt_d           = 4'd0;
            awaiting_d         = 1'b0;
            push               = 1'b1;
            new_job.is_outcome = 1'b1;
            new_job.status     = StsShort;
          end
        end
        default: ;
      endcase
    end
    if (push) begin
      job_d       = new_job;
      job_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q  <= 1'b0;
      pend_q      <= '0;
      rx_cnt_q    <= '0;
      crc_acc_q   <= CrcInit;
      hdr_good_q  <= 1'b1;
      data_q      <= '0;
      crc_lo_q    <= '0;
      job_valid_q <= 1'b0;
    end else begin
      awaiting_q  <= awaiting_d;
      pend_q      <= pend_d;
      rx_cnt_q    <= rx_cnt_d;
      crc_acc_q   <= crc_acc_d;
      hdr_good_q  <= hdr_good_d;
      data_q      <= data_d;
      crc_lo_q    <= crc_lo_d;
      job_valid_q <= job_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

// File: hdl/mbm_emit.sv
// Back end: sends request frames byte by byte and settles readings in the value RAM.
// Depends on mbm_pkg and on mbm_ram for the held readings.
module mbm_emit import mbm_pkg::*; #(
  parameter int NumQ = NumQuantities
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      job_take_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int QIW = (NumQ > 1) ? $clog2(NumQ) : 1;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] STx   = 2'd1;
  localparam logic [1:0] SOut  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [2:0]      idx_q, idx_d;
  logic [15:0]     crc_q, crc_d;
  job_t            cur_q, cur_d;
  logic [NumQ-1:0] vld_q, vld_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  logic            out_free, ram_we, ram_re;
  logic [QIW-1:0]  job_idx, cur_idx;
  logic [31:0]     ram_rdata;
  logic [15:0]     reg_addr;
  logic [7:0]      tx_byte;

  assign out_free = !out_valid_q || out_ready_i;
  assign job_idx  = QIW'(job_i.quantity);
  assign cur_idx  = QIW'(cur_q.quantity);
  assign reg_addr = reg_of_quantity(cur_q.quantity);

  mbm_ram #(
    .Width(32),
    .Depth(NumQ)
  ) u_values (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(job_idx),
    .wdata_i(job_i.data),
    .re_i   (ram_re),
    .raddr_i(job_idx),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    unique case (idx_q)
      3'd0:    tx_byte = cur_q.addr;
      3'd1:    tx_byte = FuncReadInput;
      3'd2:    tx_byte = reg_addr[15:8];
      3'd3:    tx_byte = reg_addr[7:0];
      3'd4:    tx_byte = RegCount[15:8];
      3'd5:    tx_byte = RegCount[7:0];
      3'd6:    tx_byte = crc_q[7:0];
      3'd7:    tx_byte = crc_q[15:8];
      default: tx_byte = 8'h00;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    crc_d       = crc_q;
    cur_d       = cur_q;
    vld_d       = vld_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    job_take_o  = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (job_valid_i) begin
          job_take_o = 1'b1;
          cur_d      = job_i;
          if (job_i.is_outcome) begin
            if (job_i.status == StsAccepted) begin
              ram_we         = 1'b1;
              vld_d[job_idx] = 1'b1;
            end else begin
              ram_re = 1'b1;
            end
            state_d = SOut;
          end else begin
            idx_d   = 3'd0;
            crc_d   = CrcInit;
            state_d = STx;
          end
        end
      end
      STx: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d                = '0;
          out_d.kind           = KindTx;
          out_d.tx_byte        = tx_byte;
          out_d.which_quantity = cur_q.quantity;
          out_d.last_of_run    = (idx_q == 3'd7);
          if (idx_q < 3'd6) crc_d = crc16_byte(crc_q, tx_byte);
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) state_d = SIdle;
        end
      end
      SOut: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d                = '0;
          out_d.kind           = KindOutcome;
          out_d.last_of_run    = 1'b1;
          out_d.which_quantity = cur_q.quantity;
          out_d.status         = cur_q.status;
          if (cur_q.status == StsAccepted) begin
            out_d.reading = cur_q.data;
          end else if (vld_q[cur_idx]) begin
            out_d.reading = ram_rdata;
          end
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      idx_q       <= '0;
      crc_q       <= CrcInit;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      crc_q       <= crc_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: hdl/mbm_checker.sv
// Port-level checks of the meter reader, bound to the top level.
// Depends on mbm_pkg for the output struct and the kind and status codes.
module mbm_checker import mbm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output transaction changed while stalled");

  a_tx_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KindTx |->
      out_item_o.reading == 32'd0 && out_item_o.status == StsAccepted)
    else $error("transmit transaction carries reading or status");

  a_outcome_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KindOutcome |->
      out_item_o.last_of_run && out_item_o.tx_byte == 8'h00)
    else $error("outcome transaction is not the last of its run");

  a_accepted_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KindOutcome && out_item_o.status == StsAccepted |->
      out_item_o.reading[30:0] != 31'd0)
    else $error("accepted reading is zero");

endmodule

bind modbus_rtu_meter_reader mbm_checker u_mbm_checker (.*);

// File: test/mbm_result_check.sv
// Result checker for the Modbus RTU meter reader: watches the input, output and register
// ports, predicts every output transaction and compares it with what the block produces.
// Depends on mbm_pkg for the transaction structs, codes and register reset values.
module mbm_result_check import mbm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_item_t             in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_item_t            out_item_i,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic [AddrWidth-1:0] paddr_i,
  input  logic [31:0]          pwdata_i,
  input  logic                 pready_i,
  output int                   owed_count_o,
  output int                   fault_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  cfg_slave;
  logic        cfg_enable;
  logic [30:0] cfg_limit [3];

  logic [31:0] held [NumQuantities];
  logic        awaiting;
  logic [2:0]  pend_q;
  logic [3:0]  rx_cnt;
  logic [15:0] crc_acc;
  logic        hdr_ok;
  logic [31:0] data_word;
  logic [7:0]  crc_lo;

  out_item_t   owed_results [$];

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] register_of(input logic [2:0] q);
    case (q)
      3'd0:    return 16'h0000;
      3'd1:    return 16'h0006;
      3'd2:    return 16'h000C;
      3'd3:    return 16'h0156;
      3'd4:    return 16'h0180;
      default: return 16'h0000;
    endcase
  endfunction

  // Only voltage, current and power carry a limit; NaN counts as above it.
  function automatic logic [2:0] reading_verdict(input logic [2:0] q, input logic [31:0] v);
    if (v[30:0] == 31'h0) return StsZero;
    if (q > 3'd2) return StsAccepted;
    if (v[30:23] == 8'hFF && v[22:0] != 23'h0) return StsOverLimit;
    if (!v[31] && v[30:0] > cfg_limit[q[1:0]]) return StsOverLimit;
    return StsAccepted;
  endfunction

  task automatic push_result(input logic kind, input logic [7:0] tx, input logic last,
                             input logic [2:0] q, input logic [31:0] rd,
                             input logic [2:0] sts);
    out_item_t r;
    r.kind           = kind;
    r.tx_byte        = tx;
    r.last_of_run    = last;
    r.which_quantity = q;
    r.reading        = rd;
    r.status         = sts;
    owed_results.push_back(r);
  endtask

  task automatic close_reply(input logic [2:0] sts);
    logic [31:0] rd;
    awaiting = 1'b0;
    rd = '0;
    if (pend_q < NumQuantities) begin
      if (sts == StsAccepted) held[pend_q] = data_word;
      rd = held[pend_q];
    end
    push_result(KindOutcome, 8'h00, 1'b1, pend_q, rd, sts);
  endtask

  task automatic step_meter_master(input in_item_t it);
    logic [7:0]  frame [8];
    logic [15:0] crc;
    logic [15:0] reg_addr;
    logic [2:0]  verdict;
    case (it.action)
      ActRequest: begin
        if (cfg_enable && it.quantity < NumQuantities) begin
          reg_addr = register_of(it.quantity);
          frame[0] = cfg_slave;
          frame[1] = FuncReadInput;
          frame[2] = reg_addr[15:8];
          frame[3] = reg_addr[7:0];
          frame[4] = RegCount[15:8];
          frame[5] = RegCount[7:0];
          crc = CrcInit;
          for (int i = 0; i < 6; i++) crc = crc_fold(crc, frame[i]);
          frame[6] = crc[7:0];
          frame[7] = crc[15:8];
          for (int i = 0; i < 8; i++) begin
            push_result(KindTx, frame[i], i == 7, it.quantity, '0, '0);
          end
          awaiting  = 1'b1;
          pend_q    = it.quantity;
          rx_cnt    = '0;
          crc_acc   = CrcInit;
          hdr_ok    = 1'b1;
          data_word = '0;
          crc_lo    = '0;
        end
      end
      ActRxByte: begin
        if (awaiting) begin
          if (rx_cnt < 4'd7) begin
            crc_acc = crc_fold(crc_acc, it.rx_byte);
            if ((rx_cnt == 4'd0 && it.rx_byte != cfg_slave) ||
                (rx_cnt == 4'd1 && it.rx_byte != FuncReadInput) ||
                (rx_cnt == 4'd2 && it.rx_byte != RespByteCount)) begin
              hdr_ok = 1'b0;
            end
            if (rx_cnt >= 4'd3) data_word = {data_word[23:0], it.rx_byte};
            rx_cnt++;
          end else if (rx_cnt == 4'd7) begin
            crc_lo = it.rx_byte;
            rx_cnt = 4'd8;
          end else begin
            rx_cnt = '0;
            if (!hdr_ok) verdict = StsHeader;
            else if ({it.rx_byte, crc_lo} != crc_acc) verdict = StsCrc;
            else verdict = reading_verdict(pend_q, data_word);
            close_reply(verdict);
          end
        end
      end
      ActTimeout: begin
        if (awaiting) begin
          rx_cnt = '0;
          close_reply(StsShort);
        end
      end
      default: ;
    endcase
  endtask

  task automatic match_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fault_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      cfg_slave     = SlaveAddrReset;
      cfg_enable    = 1'b0;
      cfg_limit[0]  = VoltLimitReset;
      cfg_limit[1]  = CurrLimitReset;
      cfg_limit[2]  = PowerLimitReset;
      for (int i = 0; i < NumQuantities; i++) held[i] = '0;
      awaiting      = 1'b0;
      pend_q        = '0;
      rx_cnt        = '0;
      crc_acc       = CrcInit;
      hdr_ok        = 1'b1;
      data_word     = '0;
      crc_lo        = '0;
      owed_results.delete();
      fault_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (owed_results.size() == 0) begin
          $error("output transaction with nothing predicted: kind %0d tx_byte %0h status %0d",
                 out_item_i.kind, out_item_i.tx_byte, out_item_i.status);
          fault_count_o++;
        end else begin
          want = owed_results.pop_front();
          match_field("kind", want.kind, out_item_i.kind);
          match_field("tx_byte", want.tx_byte, out_item_i.tx_byte);
          match_field("last_of_run", want.last_of_run, out_item_i.last_of_run);
          match_field("which_quantity", want.which_quantity, out_item_i.which_quantity);
          match_field("reading", want.reading, out_item_i.reading);
          match_field("status", want.status, out_item_i.status);
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[AddrWidth-1:2])
          RegSlaveAddr:  cfg_slave    = pwdata_i[7:0];
          RegEnable:     cfg_enable   = pwdata_i[0];
          RegVoltLimit:  cfg_limit[0] = pwdata_i[30:0];
          RegCurrLimit:  cfg_limit[1] = pwdata_i[30:0];
          RegPowerLimit: cfg_limit[2] = pwdata_i[30:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) step_meter_master(in_item_i);
    end
    owed_count_o <= owed_results.size();
  end

endmodule

// File: test/modbus_rtu_meter_reader_tb.sv
// Testbench top of the Modbus RTU meter reader: drives requests, reply bytes, timeouts and
// register writes, and gives the verdict. Depends on mbm_pkg, the block and mbm_result_check.
module modbus_rtu_meter_reader_tb import mbm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ActReserved  = 2'd3;
  localparam int         FlawNone     = 0;
  localparam int         FlawHeader   = 1;
  localparam int         FlawCrc      = 2;
  localparam int         FlawBoth     = 3;
  localparam int         SettleCycles = 16;
  localparam int         QuietLimit   = 4000;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [AddrWidth-1:0] paddr     = '0;
  logic [31:0]          pwdata    = '0;
  logic [31:0]          prdata;
  logic                 pready;

  int owed_count;
  int fault_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  int quiet_cycles  = 0;

  logic [7:0]  bus_addr = SlaveAddrReset;
  logic [30:0] lim_bits [3] = '{VoltLimitReset, CurrLimitReset, PowerLimitReset};

  modbus_rtu_meter_reader dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  mbm_result_check reading_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_item_i     (in_item),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_item_i    (out_item),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .owed_count_o  (owed_count),
    .fault_count_o (fault_count)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
        $display("[modbus_rtu_meter_reader] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [2:0] q, input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= '{action: act, quantity: q, rx_byte: b};
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (owed_count != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegSlaveAddr:  bus_addr    = val[7:0];
      RegVoltLimit:  lim_bits[0] = val[30:0];
      RegCurrLimit:  lim_bits[1] = val[30:0];
      RegPowerLimit: lim_bits[2] = val[30:0];
      default: ;
    endcase
  endtask

  // Builds a reply for the current slave address, corrupts it as asked, and sends the
  // first n_bytes of it.
  task automatic send_reply(input logic [31:0] word, input int flaw, input int n_bytes);
    logic [7:0]  frame [9];
    logic [15:0] crc;
    int          pos;
    frame[0] = bus_addr;
    frame[1] = FuncReadInput;
    frame[2] = RespByteCount;
    frame[3] = word[31:24];
    frame[4] = word[23:16];
    frame[5] = word[15:8];
    frame[6] = word[7:0];
    if (flaw == FlawHeader || flaw == FlawBoth) begin
      pos = $urandom_range(2);
      frame[pos] = frame[pos] ^ 8'(1 << $urandom_range(7));
    end
    crc = CrcInit;
    for (int i = 0; i < 7; i++) begin
      crc = crc ^ {8'h00, frame[i]};
      for (int k = 0; k < 8; k++) crc = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
    end
    frame[7] = crc[7:0];
    frame[8] = crc[15:8];
    if (flaw == FlawCrc || flaw == FlawBoth) begin
      pos = 7 + $urandom_range(1);
      frame[pos] = frame[pos] ^ 8'(1 << $urandom_range(7));
    end
    for (int i = 0; i < n_bytes; i++) send_item(ActRxByte, 3'($urandom_range(7)), frame[i]);
  endtask

  initial begin
    logic [2:0]  q;
    logic [31:0] word;
    int          pick;
    int          target;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 22;
    recv_idle_pct = 76;
    send_item(ActRequest, 3'd0, 8'h00);
    send_item(ActRxByte, 3'd0, 8'hFF);
    send_item(ActTimeout, 3'd7, 8'h00);
    send_item(ActReserved, 3'd7, 8'hFF);
    drain();
    reg_write(RegEnable, 32'd1);
    send_item(ActRequest, 3'd5, 8'h00);
    send_item(ActRequest, 3'd7, 8'hFF);
    send_item(ActRequest, 3'd0, 8'h00);
    send_reply(32'h4366_0000, FlawNone, 9);
    send_item(ActRequest, 3'd2, 8'h00);
    send_item(ActTimeout, 3'd2, 8'h00);
    send_item(ActRequest, 3'd1, 8'h00);
    send_item(ActRequest, 3'd4, 8'h00);
    send_item(ActTimeout, 3'd0, 8'h00);

    target = items_sent;
    for (int seg = 0; seg < 4; seg++) begin
      drain();
      case (seg)
        0: begin
          send_idle_pct = 22;
          recv_idle_pct = 76;
          reg_write(RegSlaveAddr, 32'($urandom_range(254, 1)));
          reg_write(RegVoltLimit, 32'h43C8_0000);
          reg_write(RegCurrLimit, 32'h42C8_0000);
          reg_write(RegPowerLimit, 32'h46C3_5000);
          target += 100;
        end
        1: begin
          send_idle_pct = 76;
          recv_idle_pct = 22;
          reg_write(RegEnable, 32'd0);
          reg_write(RegSlaveAddr, 32'h0000_0000);
          target += 20;
        end
        2: begin
          reg_write(RegEnable, 32'd1);
          reg_write(RegVoltLimit, 32'h0000_0000);
          reg_write(RegCurrLimit, 32'h7FFF_FFFF);
          reg_write(RegPowerLimit, $urandom);
          target += 80;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          reg_write(RegSlaveAddr, 32'h0000_00FF);
          reg_write(RegVoltLimit, $urandom);
          reg_write(RegCurrLimit, 32'hFFFF_FFFF);
          reg_write(RegPowerLimit, 32'h0000_0000);
          target += 100;
        end
      endcase

      while (items_sent < target) begin
        if ($urandom_range(9) == 0) begin
          send_item(2'($urandom_range(3)), 3'($urandom_range(7)), 8'($urandom_range(255)));
        end else begin
          q = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
          send_item(ActRequest, q, 8'($urandom_range(255)));
          case ($urandom_range(7))
            0: word = $urandom;
            1: word = {1'($urandom_range(1)), 31'h0};
            2: word = {1'($urandom_range(1)), 8'hFF, 22'($urandom), 1'b1};
            3: begin
              if (q < 3'd3) word = {1'b0, lim_bits[q[1:0]]} + 32'($urandom_range(2)) - 32'd1;
              else word = $urandom;
            end
            4: word = 32'h7F80_0000;
            5: word = {1'b1, 31'($urandom)};
            default: word = {2'b00, 30'($urandom)};
          endcase
          pick = $urandom_range(9);
          if (pick < 6) begin
            send_reply(word, FlawNone, 9);
          end else if (pick == 6) begin
            send_reply(word, FlawHeader, 9);
          end else if (pick == 7) begin
            send_reply(word, FlawCrc, 9);
          end else if (pick == 8) begin
            send_reply(word, FlawBoth, 9);
          end else begin
            send_reply(word, FlawNone, $urandom_range(8));
            if ($urandom_range(1) == 1) begin
              send_item(ActTimeout, 3'($urandom_range(7)), 8'($urandom_range(255)));
            end
          end
        end
      end
    end

    drain();
    if (fault_count == 0) begin
      $display("[modbus_rtu_meter_reader] OK");
    end else begin
      $display("[modbus_rtu_meter_reader] ERROR");
    end
    $finish;
  end

endmodule
